// File: hw/rtl/tknl_pkg.sv
package tknl_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int K_W = $clog2(LIST_DEPTH + 1);

  localparam int MODE_W = 2;
  localparam int CID_W = 24;
  localparam int ID_W = 25;
  localparam int DIST_W = 32;
  localparam int RIDX_W = 4;
  localparam int SIZE_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(10);
  localparam logic [ID_W-1:0] ID_EMPTY = '1;
  localparam logic [DIST_W-1:0] DIST_EMPTY = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_OFFER = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef struct packed {
    logic              clear;
    logic              offer;
    logic [ID_W-1:0]   cid;
    logic [DIST_W-1:0] cdist;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic              blocked;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
  } link_t;

endpackage

// File: hw/rtl/tknl_ifs.sv
interface tknl_in_if;
  logic                                valid;
  logic                                ready;
  logic [tknl_pkg::MODE_W-1:0]         mode;
  logic [tknl_pkg::CID_W-1:0]          candidate_id;
  logic [tknl_pkg::DIST_W-1:0]         candidate_distance;
  logic [tknl_pkg::RIDX_W-1:0]         read_index;

  modport source (output valid, mode, candidate_id, candidate_distance, read_index,
                  input ready);
  modport sink (input valid, mode, candidate_id, candidate_distance, read_index,
                output ready);
endinterface

interface tknl_out_if;
  logic                                valid;
  logic                                ready;
  logic [tknl_pkg::DIST_W-1:0]         kth_distance;
  logic                                inserted;
  logic signed [tknl_pkg::ID_W-1:0]    entry_id;
  logic [tknl_pkg::DIST_W-1:0]         entry_distance;

  modport source (output valid, kth_distance, inserted, entry_id, entry_distance,
                  input ready);
  modport sink (input valid, kth_distance, inserted, entry_id, entry_distance,
                output ready);
endinterface

interface tknl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tknl_pkg::SIZE_W-1:0]         data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/top_k_nearest_list.sv
// Keeps an ascending list of the best candidates by distance, of length k.
// The input channel carries one command per transfer: clear empties the list,
// offer presents a candidate id and distance, and read returns one slot.
// Every command yields exactly one transfer on the result channel, which
// always carries the distance in slot k-1 as it stands after the command.
// The list is a row of identical cells, one per slot. On an offer every cell
// compares the candidate with its own entry in the same cycle, a found and a
// blocked flag pass from each cell to the next, and the cells behind the
// insertion point take their neighbor's entry.
// A command's result is registered and appears on the
// cycle after the transfer. One command is taken per cycle as long as the
// result side keeps up. The output register lets a new command in during
// the same cycle that the waiting result is taken; while the receiver
// stalls, in_ch.ready stays low and the list holds still.
// The configuration channel writes k and is always ready; the user must write it
// only while no command is in flight, which the block itself does not enforce.
// Reset empties every slot, sets k to 10 and drops any waiting result.
module top_k_nearest_list (
  input  logic       clk,
  input  logic       rst_n,
  tknl_in_if.sink    in_ch,
  tknl_out_if.source out_ch,
  tknl_cfg_if.sink   cfg_ch
);

  logic [tknl_pkg::SIZE_W-1:0] list_size_r;
  logic [tknl_pkg::K_W-1:0]    k_eff;
  logic [tknl_pkg::IDX_W-1:0]  k_idx;
  logic [tknl_pkg::IDX_W-1:0]  rd_sel;
  logic                        rd_ok;
  logic                        accept;
  logic                        out_valid_r, out_valid_nxt;
  tknl_pkg::cmd_t              cmd;
  tknl_pkg::link_t             links [tknl_pkg::LIST_DEPTH+1];
  logic [tknl_pkg::DIST_W-1:0] dist_nxt [tknl_pkg::LIST_DEPTH];
  logic [tknl_pkg::ID_W-1:0]   slot_id [tknl_pkg::LIST_DEPTH];
  logic [tknl_pkg::DIST_W-1:0] slot_dist [tknl_pkg::LIST_DEPTH];
  logic [tknl_pkg::LIST_DEPTH-1:0] active;

  logic [tknl_pkg::DIST_W-1:0] kth_r, kth_nxt;
  logic                        ins_r, ins_nxt;
  logic [tknl_pkg::ID_W-1:0]   eid_r, eid_nxt;
  logic [tknl_pkg::DIST_W-1:0] edist_r, edist_nxt;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_size_r <= tknl_pkg::SIZE_RESET;
    end else if (cfg_ch.valid) begin
      list_size_r <= cfg_ch.data;
    end
  end

  always_comb begin
    if (list_size_r == '0) begin
      k_eff = tknl_pkg::K_W'(1);
    end else if (int'(list_size_r) > tknl_pkg::LIST_DEPTH) begin
      k_eff = tknl_pkg::K_W'(tknl_pkg::LIST_DEPTH);
    end else begin
      k_eff = tknl_pkg::K_W'(list_size_r);
    end
  end

  assign k_idx  = tknl_pkg::IDX_W'(k_eff - tknl_pkg::K_W'(1));
  assign rd_sel = tknl_pkg::IDX_W'(in_ch.read_index);
  assign rd_ok  = int'(in_ch.read_index) < tknl_pkg::LIST_DEPTH;

  always_comb begin
    cmd.clear = accept && (in_ch.mode == tknl_pkg::MODE_CLEAR);
    cmd.offer = accept && (in_ch.mode == tknl_pkg::MODE_OFFER);
    cmd.cid   = {1'b0, in_ch.candidate_id};
    cmd.cdist = in_ch.candidate_distance;
  end

  assign links[0] = '0;

  for (genvar i = 0; i < tknl_pkg::LIST_DEPTH; i++) begin : g_cell
    assign active[i] = tknl_pkg::K_W'(i) < k_eff;

    tknl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .active     (active[i]),
      .link_in    (links[i]),
      .link_out   (links[i+1]),
      .dist_nxt_o (dist_nxt[i])
    );

    assign slot_id[i]   = links[i+1].id;
    assign slot_dist[i] = links[i+1].distance;
  end

  always_comb begin
    kth_nxt   = dist_nxt[k_idx];
    ins_nxt   = 1'b0;
    eid_nxt   = '0;
    edist_nxt = '0;
    case (tknl_pkg::mode_t'(in_ch.mode))
      tknl_pkg::MODE_OFFER: begin
        ins_nxt = links[tknl_pkg::LIST_DEPTH].found;
      end
      tknl_pkg::MODE_READ: begin
        if (rd_ok) begin
          eid_nxt   = slot_id[rd_sel];
          edist_nxt = slot_dist[rd_sel];
        end else begin
          eid_nxt   = tknl_pkg::ID_EMPTY;
          edist_nxt = tknl_pkg::DIST_EMPTY;
        end
      end
      default: begin
        ins_nxt = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kth_r   <= kth_nxt;
      ins_r   <= ins_nxt;
      eid_r   <= eid_nxt;
      edist_r <= edist_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kth_distance   = kth_r;
  assign out_ch.inserted       = ins_r;
  assign out_ch.entry_id       = eid_r;
  assign out_ch.entry_distance = edist_r;

endmodule

// File: hw/rtl/tknl_cell.sv
module tknl_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tknl_pkg::cmd_t                cmd,
  input  logic                          active,
  input  tknl_pkg::link_t               link_in,
  output tknl_pkg::link_t               link_out,
  output logic [tknl_pkg::DIST_W-1:0]   dist_nxt_o
);

  logic [tknl_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [tknl_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic                        dup;
  logic                        less;
  logic                        ins;
  logic                        shift;

  assign dup   = active && (id_r == cmd.cid);
  assign less  = active && (cmd.cdist < dist_r);
  assign ins   = cmd.offer && !link_in.found && !link_in.blocked && !dup && less;
  assign shift = cmd.offer && active && link_in.found;

  always_comb begin
    id_nxt   = id_r;
    dist_nxt = dist_r;
    if (cmd.clear) begin
      id_nxt   = tknl_pkg::ID_EMPTY;
      dist_nxt = tknl_pkg::DIST_EMPTY;
    end else if (ins) begin
      id_nxt   = cmd.cid;
      dist_nxt = cmd.cdist;
    end else if (shift) begin
      id_nxt   = link_in.id;
      dist_nxt = link_in.distance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r   <= tknl_pkg::ID_EMPTY;
      dist_r <= tknl_pkg::DIST_EMPTY;
    end else begin
      id_r   <= id_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign link_out.found    = link_in.found || ins;
  assign link_out.blocked  = link_in.blocked || (dup && !link_in.found);
  assign link_out.id       = id_r;
  assign link_out.distance = dist_r;
  assign dist_nxt_o        = dist_nxt;

endmodule

// File: hw/rtl/tknl_checker.sv
module tknl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [tknl_pkg::MODE_W-1:0]   in_mode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tknl_pkg::DIST_W-1:0]   out_kth_distance,
  input logic                          out_inserted,
  input logic [tknl_pkg::ID_W-1:0]     out_entry_id,
  input logic [tknl_pkg::DIST_W-1:0]   out_entry_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result was withdrawn before its transfer.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("Accepted command produced no result.");

  a_ins_offer_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode != tknl_pkg::MODE_OFFER) |=> !out_inserted)
    else $error("Inserted flag set for a command other than offer.");

  a_clear_kth: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == tknl_pkg::MODE_CLEAR)
    |=> out_kth_distance == tknl_pkg::DIST_EMPTY)
    else $error("Last slot not empty after clear.");

  a_entry_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode != tknl_pkg::MODE_READ)
    |=> (out_entry_id == '0) && (out_entry_distance == '0))
    else $error("Entry fields nonzero for a command other than read.");

endmodule

bind top_k_nearest_list tknl_checker u_tknl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_mode            (in_ch.mode),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kth_distance   (out_ch.kth_distance),
  .out_inserted       (out_ch.inserted),
  .out_entry_id       (out_ch.entry_id),
  .out_entry_distance (out_ch.entry_distance)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tknl_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;
  localparam int NUM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 20;
  localparam int CFG_SETTLE = 4;

  typedef struct packed {
    logic [DIST_W-1:0] kth_distance;
    logic              inserted;
    logic [ID_W-1:0]   entry_id;
    logic [DIST_W-1:0] entry_distance;
  } list_result_t;

  class ListScoreboard;
    logic [ID_W-1:0]   slot_ids[LIST_DEPTH];
    logic [DIST_W-1:0] slot_dists[LIST_DEPTH];
    logic [SIZE_W-1:0] size_reg;
    list_result_t      expected_q[$];
    int                errors;
    int                checked;
    int                entered;

    function new();
      size_reg = SIZE_RESET;
      errors = 0;
      checked = 0;
      entered = 0;
      empty_slots();
    endfunction

    function void empty_slots();
      for (int i = 0; i < LIST_DEPTH; i++) begin
        slot_ids[i] = ID_EMPTY;
        slot_dists[i] = DIST_EMPTY;
      end
    endfunction

    function int kept_count();
      int k;
      k = int'(size_reg);
      if (k < 1) k = 1;
      if (k > LIST_DEPTH) k = LIST_DEPTH;
      return k;
    endfunction

    function logic try_insert(logic [CID_W-1:0] cid, logic [DIST_W-1:0] cdist);
      int k;
      int pos;
      k = kept_count();
      for (pos = 0; pos < k; pos++) begin
        if (slot_ids[pos] == {1'b0, cid}) return 1'b0;
        if (cdist < slot_dists[pos]) break;
      end
      if (pos >= k) return 1'b0;
      for (int j = k - 1; j > pos; j--) begin
        slot_ids[j] = slot_ids[j-1];
        slot_dists[j] = slot_dists[j-1];
      end
      slot_ids[pos] = {1'b0, cid};
      slot_dists[pos] = cdist;
      return 1'b1;
    endfunction

    function void note_command(logic [MODE_W-1:0] mode, logic [CID_W-1:0] cid,
                               logic [DIST_W-1:0] cdist, logic [RIDX_W-1:0] ridx);
      list_result_t res;
      res = '0;
      case (mode)
        MODE_CLEAR: empty_slots();
        MODE_OFFER: begin
          res.inserted = try_insert(cid, cdist);
          if (res.inserted) entered++;
        end
        MODE_READ: begin
          if (int'(ridx) < LIST_DEPTH) begin
            res.entry_id = slot_ids[ridx];
            res.entry_distance = slot_dists[ridx];
          end else begin
            res.entry_id = ID_EMPTY;
            res.entry_distance = DIST_EMPTY;
          end
        end
        default: ;
      endcase
      res.kth_distance = slot_dists[kept_count() - 1];
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void write_size(logic [SIZE_W-1:0] value);
      size_reg = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.kth_distance !== exp.kth_distance) begin
        $display("%0t: kth_distance expected %h actual %h", $time,
                 exp.kth_distance, got.kth_distance);
        errors++;
      end
      if (got.inserted !== exp.inserted) begin
        $display("%0t: inserted expected %b actual %b", $time, exp.inserted, got.inserted);
        errors++;
      end
      if (got.entry_id !== exp.entry_id) begin
        $display("%0t: entry_id expected %h actual %h", $time, exp.entry_id, got.entry_id);
        errors++;
      end
      if (got.entry_distance !== exp.entry_distance) begin
        $display("%0t: entry_distance expected %h actual %h", $time,
                 exp.entry_distance, got.entry_distance);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   no_idle = 1'b0;
  int   cmd_count = 0;
  int   size_settings = 0;

  ListScoreboard sb;

  tknl_in_if  in_ch ();
  tknl_out_if out_ch ();
  tknl_cfg_if cfg_ch ();

  top_k_nearest_list dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance(int span);
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 9) return DIST_W'($urandom_range(0, span));
    if (sel < 13) return $urandom;
    if (sel == 13) return DIST_EMPTY;
    if (sel == 14) return DIST_EMPTY - 1;
    return '0;
  endfunction

  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [CID_W-1:0] cid,
                          input logic [DIST_W-1:0] cdist, input logic [RIDX_W-1:0] ridx);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.candidate_id <= cid;
    in_ch.candidate_distance <= cdist;
    in_ch.read_index <= ridx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_command(mode, cid, cdist, ridx);
    if (mode != MODE_UNKNOWN) cmd_count++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    wait_idle();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_size(value);
    size_settings++;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_cmd(MODE_READ, CID_W'($urandom), $urandom, 4'd0);
    send_cmd(MODE_READ, CID_W'($urandom), $urandom, 4'd15);
    send_cmd(MODE_UNKNOWN, CID_W'($urandom), $urandom, RIDX_W'($urandom));
    send_cmd(MODE_OFFER, 24'd0, DIST_EMPTY, 4'd0);
    send_cmd(MODE_OFFER, 24'hFFFFFF, 32'd0, 4'd0);
    send_cmd(MODE_OFFER, 24'hFFFFFF, 32'd5, 4'd0);
    send_cmd(MODE_OFFER, 24'd7, 32'd0, 4'd0);
    send_cmd(MODE_OFFER, 24'd9, 32'd50, 4'd0);
    send_cmd(MODE_OFFER, 24'd20, 32'd10, 4'd0);
    send_cmd(MODE_OFFER, 24'd9, 32'd20, 4'd0);
    send_cmd(MODE_OFFER, 24'd9, 32'd5, 4'd0);
    send_cmd(MODE_OFFER, 24'h123456, DIST_EMPTY - 1, 4'd0);
    for (int i = 0; i < 6; i++) begin
      send_cmd(MODE_READ, '0, '0, RIDX_W'(i));
    end
    send_cmd(MODE_UNKNOWN, '1, '1, '1);
    send_cmd(MODE_CLEAR, '1, '1, '1);
    send_cmd(MODE_READ, '0, '0, 4'd3);
    send_cmd(MODE_READ, '0, '0, 4'd12);
  endtask

  task automatic run_random_phase(input int items);
    int target;
    int n;
    int pool;
    int span;
    logic [CID_W-1:0] base;
    logic [MODE_W-1:0] mode;
    target = cmd_count + items;
    while (cmd_count < target) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) begin
          send_cmd(MODE_CLEAR, CID_W'($urandom), $urandom, RIDX_W'($urandom));
        end
        n = $urandom_range(4, 30);
        pool = $urandom_range(2, 40);
        span = ($urandom_range(0, 1) == 0) ? $urandom_range(4, 64) : $urandom_range(1000, 1 << 30);
        base = ($urandom_range(0, 1) == 0) ? CID_W'($urandom_range(0, 32'hFFFF00)) : '0;
        repeat (n) begin
          if (cmd_count >= target) break;
          if ($urandom_range(0, 5) == 0) begin
            send_cmd(MODE_READ, CID_W'($urandom), $urandom, RIDX_W'($urandom));
          end else if ($urandom_range(0, 15) == 0) begin
            send_cmd(MODE_OFFER, CID_W'($urandom), pick_distance(span), RIDX_W'($urandom));
          end else begin
            send_cmd(MODE_OFFER, base + CID_W'($urandom_range(0, pool)),
                     pick_distance(span), RIDX_W'($urandom));
          end
        end
        repeat ($urandom_range(1, 6)) begin
          if (cmd_count >= target) break;
          send_cmd(MODE_READ, CID_W'($urandom), $urandom, RIDX_W'($urandom));
        end
      end else begin
        repeat ($urandom_range(3, 10)) begin
          if (cmd_count >= target) break;
          mode = MODE_W'($urandom_range(0, 3));
          send_cmd(mode, CID_W'($urandom), $urandom, RIDX_W'($urandom));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_side
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1 || out_ch.ready !== 1'b1);
      sb.check_result('{out_ch.kth_distance, out_ch.inserted, out_ch.entry_id,
                        out_ch.entry_distance});
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] sizes[10];
    int per_phase;
    sizes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd10, 5'd2, 5'd15, 5'd8};
    sb = new();
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_CLEAR;
    in_ch.candidate_id <= '0;
    in_ch.candidate_distance <= '0;
    in_ch.read_index <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    out_ch.ready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    per_phase = (NUM_ITEMS - cmd_count) / 10;
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      run_random_phase(per_phase);
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Ran %0d commands across %0d list size settings; %0d results checked.",
             cmd_count, size_settings, sb.checked);
    $display("%0d offered candidates entered the list.", sb.entered);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
